@@ hw/rtl/dvfs_vote_frequency_selector_macros.svh @@
// Assertion macros for the DVFS vote frequency selector.
`ifndef DVFS_VOTE_FREQUENCY_SELECTOR_MACROS_SVH
`define DVFS_VOTE_FREQUENCY_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DVFS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DVFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dvfs_pkg.sv @@
// Shared constants and helpers for the DVFS vote frequency selector.
package dvfs_pkg;

    localparam int MAX_LEVELS_DEF = 16;

    localparam int FRAC_W  = 17;
    localparam int WIN_W   = 32;
    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int VOTE_W  = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE       = 17'h10000;
    localparam logic [CNT_W-1:0]  FREQ_COUNT_RST = 5'd16;
    localparam logic [CNT_W-1:0]  FREQ_COUNT_MIN = 5'd2;

    localparam int IN_BITS   = FRAC_W + WIN_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = IDX_W + 1 + WIN_W + WIN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    function automatic logic [VOTE_W-1:0] sat_inc(input logic [VOTE_W-1:0] v);
        sat_inc = (v == {VOTE_W{1'b1}}) ? v : v + VOTE_W'(1);
    endfunction

endpackage

@@ hw/rtl/dvfs_vote_ram.sv @@
// Vote counter memory: one write and one registered read port, entries read zero until written.
module dvfs_vote_ram #(
    parameter int MAX_LEVELS = dvfs_pkg::MAX_LEVELS_DEF,
    parameter int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [LVL_W-1:0]            wr_addr,
    input  logic [dvfs_pkg::VOTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [LVL_W-1:0]            rd_addr,
    output logic [dvfs_pkg::VOTE_W-1:0] rd_data
);

    logic [dvfs_pkg::VOTE_W-1:0] mem [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]       valid_reg;
    logic [dvfs_pkg::VOTE_W-1:0] rd_mem_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

@@ hw/rtl/dvfs_vote_frequency_selector.sv @@
// Top level of the DVFS vote frequency selector.
// Throughput: one report per cycle unless the output stalls, set by the single
// read-modify-write of the vote memory per report, with the last written count
// forwarded to a following read.
// Reset: vote counters read zero through per-entry valid bits, so no clearing pass;
// level, window count and pipeline clear at once, freq_count returns to 16.
`include "dvfs_vote_frequency_selector_macros.svh"

module dvfs_vote_frequency_selector #(
    parameter int MAX_LEVELS = dvfs_pkg::MAX_LEVELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dvfs_pkg::CNT_W-1:0]      cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [16:0] bound_fraction, [48:17] window_in, [55:49] zero
    input  logic [dvfs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] freq_index, [4] freq_changed, [36:5] next_window,
    // [68:37] local_window_count, [71:69] zero
    output logic [dvfs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PROD_W = dvfs_pkg::VOTE_W + LVL_W;
    localparam int FMUL_W = dvfs_pkg::FRAC_W - 1 + dvfs_pkg::CNT_W;

    logic [dvfs_pkg::CNT_W-1:0]  freq_count_reg;

    logic                        p1_valid_reg;
    logic [LVL_W-1:0]            p1_target_reg;
    logic [dvfs_pkg::WIN_W-1:0]  p1_win_reg;
    logic                        p1_fwd_reg;
    logic [dvfs_pkg::VOTE_W-1:0] last_vote_reg;

    logic [LVL_W-1:0]            cur_level_reg;
    logic [dvfs_pkg::VOTE_W-1:0] cur_votes_reg;
    logic [dvfs_pkg::WIN_W-1:0]  win_count_reg;

    logic                        m_tvalid_reg;
    logic [dvfs_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [dvfs_pkg::FRAC_W-1:0] frac_in;
    logic [dvfs_pkg::WIN_W-1:0]  win_in;
    logic [dvfs_pkg::CNT_W-1:0]  count;
    logic [FMUL_W-1:0]           frac_prod;
    logic [dvfs_pkg::CNT_W-1:0]  target_raw;
    logic [LVL_W-1:0]            target_in;
    logic                        accept;
    logic                        p1_adv;

    logic [dvfs_pkg::VOTE_W-1:0] rd_data;
    logic [dvfs_pkg::VOTE_W-1:0] vote_old;
    logic [dvfs_pkg::VOTE_W-1:0] vote_new;
    logic [LVL_W-1:0]            level_gap;
    logic [PROD_W-1:0]           weighted;
    logic                        change;
    logic [dvfs_pkg::WIN_W-1:0]  win_count_next;
    logic [dvfs_pkg::WIN_W-1:0]  next_window;
    logic [LVL_W-1:0]            cur_level_next;
    logic [dvfs_pkg::VOTE_W-1:0] cur_votes_next;

    assign frac_in = s_axis_tdata[dvfs_pkg::FRAC_W-1:0];
    assign win_in  = s_axis_tdata[dvfs_pkg::FRAC_W +: dvfs_pkg::WIN_W];

    always_comb
    begin
        priority if (freq_count_reg < dvfs_pkg::FREQ_COUNT_MIN)
        begin
            count = dvfs_pkg::FREQ_COUNT_MIN;
        end
        else if (int'(freq_count_reg) > MAX_LEVELS)
        begin
            count = dvfs_pkg::CNT_W'(MAX_LEVELS);
        end
        else
        begin
            count = freq_count_reg;
        end
    end

    assign frac_prod = FMUL_W'(frac_in[dvfs_pkg::FRAC_W-2:0]) * FMUL_W'(count);

    always_comb
    begin
        priority if (frac_in >= dvfs_pkg::FRAC_ONE)
        begin
            target_raw = count - dvfs_pkg::CNT_W'(1);
        end
        else if (frac_in == '0)
        begin
            target_raw = dvfs_pkg::CNT_W'(1);
        end
        else
        begin
            target_raw = frac_prod[FMUL_W-1 -: dvfs_pkg::CNT_W];
        end
    end

    assign target_in = LVL_W'(target_raw);

    assign p1_adv        = p1_valid_reg && (!m_tvalid_reg || m_axis_tready);
    assign s_axis_tready = !p1_valid_reg || p1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dvfs_vote_ram #(
        .MAX_LEVELS (MAX_LEVELS),
        .LVL_W      (LVL_W)
    ) u_vote_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (p1_adv),
        .wr_addr (p1_target_reg),
        .wr_data (vote_new),
        .rd_en   (accept),
        .rd_addr (target_in),
        .rd_data (rd_data)
    );

    assign vote_old  = p1_fwd_reg ? last_vote_reg : rd_data;
    assign vote_new  = dvfs_pkg::sat_inc(vote_old);
    assign level_gap = (p1_target_reg > cur_level_reg) ? p1_target_reg - cur_level_reg
                                                       : cur_level_reg - p1_target_reg;
    assign weighted  = PROD_W'(vote_new) * PROD_W'(level_gap);
    assign change    = (p1_target_reg != cur_level_reg) && (weighted > PROD_W'(cur_votes_reg));

    always_comb
    begin
        cur_level_next = cur_level_reg;
        cur_votes_next = cur_votes_reg;
        if (change)
        begin
            cur_level_next = p1_target_reg;
            cur_votes_next = vote_new;
            win_count_next = dvfs_pkg::WIN_W'(1);
            next_window    = dvfs_pkg::WIN_W'(1);
        end
        else
        begin
            if (p1_target_reg == cur_level_reg)
            begin
                cur_votes_next = vote_new;
            end
            win_count_next = dvfs_pkg::sat_inc(win_count_reg);
            next_window    = dvfs_pkg::sat_inc(p1_win_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_count_reg <= dvfs_pkg::FREQ_COUNT_RST;
            p1_valid_reg   <= 1'b0;
            p1_fwd_reg     <= 1'b0;
            cur_level_reg  <= '0;
            cur_votes_reg  <= '0;
            win_count_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                freq_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
                p1_fwd_reg   <= p1_adv && (p1_target_reg == target_in);
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                cur_level_reg <= cur_level_next;
                cur_votes_reg <= cur_votes_next;
                win_count_reg <= win_count_next;
                m_tvalid_reg  <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_target_reg <= target_in;
            p1_win_reg    <= win_in;
        end
        if (p1_adv)
        begin
            last_vote_reg <= vote_new;
            m_tdata_reg   <= dvfs_pkg::OUT_DATA_W'({win_count_next, next_window, change,
                                                    dvfs_pkg::IDX_W'(cur_level_next)});
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    `DVFS_ASSERT_IMPL(a_level_range, 1'b1, int'(cur_level_reg) < MAX_LEVELS,
        "current level outside the vote memory")
    `DVFS_ASSERT_IMPL(a_change_restart, m_tvalid_reg && m_tdata_reg[dvfs_pkg::IDX_W],
        m_tdata_reg[dvfs_pkg::IDX_W+1 +: dvfs_pkg::WIN_W] == dvfs_pkg::WIN_W'(1) &&
        m_tdata_reg[dvfs_pkg::IDX_W+1+dvfs_pkg::WIN_W +: dvfs_pkg::WIN_W] == dvfs_pkg::WIN_W'(1),
        "level change without window restart")
    `DVFS_ASSERT_NEXT(a_p1_hold, p1_valid_reg && !p1_adv,
        p1_valid_reg && $stable(p1_target_reg) && $stable(p1_win_reg),
        "stalled report lost its contents")
    `DVFS_ASSERT_NEXT(a_change_tracks, p1_adv && change,
        cur_level_reg == $past(p1_target_reg) && cur_votes_reg == $past(vote_new),
        "current level votes not tracked on change")

endmodule
